### rtl/motor_axis_pid_drive_defines.svh
// Assertion helpers used by the RTL of the motor axis drive.
`ifndef MOTOR_AXIS_PID_DRIVE_DEFINES_SVH
`define MOTOR_AXIS_PID_DRIVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MAPD_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mapd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MAPD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mapd next-cycle check failed");

`endif

### rtl/mapd_pkg.sv
`default_nettype none

package mapd_pkg;

  localparam int unsigned INTEGRAL_WIDTH = 48;

  localparam int unsigned ANGLE_W = 17;
  localparam int unsigned ENC_W   = 16;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned KI_W    = 32;
  localparam int unsigned KD_W    = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned SETP_W  = 18;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  // Shared serial multiplier: 17-bit multiplicand times 16-bit multiplier.
  localparam int unsigned MUL_W   = ERR_W + KD_W;
  // The divide by 256 is folded into the numerator before the divider.
  localparam int unsigned DIVN_W  = MUL_W - 8;
  localparam int unsigned KP_W    = INTEGRAL_WIDTH + KI_W;
  localparam int unsigned SUM_W   = DIVN_W + 2;
  localparam int unsigned CNT_W   = 5;

  localparam int unsigned SETP_STEPS = KD_W;
  localparam int unsigned MUL_STEPS  = KI_W;
  localparam int unsigned DIV_STEPS  = DIVN_W;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_KI    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KD    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DBAND = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOME  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCALE = 3'd6;
  localparam logic [IDX_W-1:0] REG_MODE  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETP,
    ST_ERR,
    ST_INT,
    ST_MUL,
    ST_DIV,
    ST_SUM
  } st_e;

  typedef struct packed {
    logic accept;
    logic mul_step;
    logic ki_step;
    logic div_step;
    logic out_load;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/motor_axis_pid_drive.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | target_angle, encoder_position, tick, pair
// out     | output    | out_valid_o/out_ready_i | duty_forward, duty_reverse, pid_duty, pair
// cfg     | input     | cfg_we_i (no wait)   | cfg_idx_i, cfg_wdata_i
//
// An item runs from acceptance through the angle multiply, the error and integral steps,
// the serial integral-gain multiply (carrying the 16-step derivative multiply), the restoring
// divide by the tick interval and the sum step, and then goes back to idle.
// Reset is asynchronous and active low; it loads the register defaults and clears the state.
// A new item is taken while a finished result waits in the output register; the block
// stalls only in its last step while that register is still full.
`default_nettype none
`include "motor_axis_pid_drive_defines.svh"

module motor_axis_pid_drive (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mapd_pkg::IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mapd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [mapd_pkg::ANGLE_W-1:0]     target_angle_i,
  input  wire logic [mapd_pkg::ENC_W-1:0]       encoder_position_i,
  input  wire logic [mapd_pkg::TICK_W-1:0]      current_tick_i,
  input  wire logic                             channel_pair_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [mapd_pkg::DUTY_W-1:0]           duty_forward_o,
  output logic [mapd_pkg::DUTY_W-1:0]           duty_reverse_o,
  output logic [mapd_pkg::DUTY_W-1:0]           pid_duty_o,
  output logic                                  pair_used_o
);

  localparam int unsigned IW = mapd_pkg::INTEGRAL_WIDTH;

  // Configuration registers
  logic [mapd_pkg::KI_W-1:0]   ki_gain_q;
  logic [mapd_pkg::KD_W-1:0]   kd_gain_q;
  logic [mapd_pkg::DUTY_W-1:0] max_duty_q, min_duty_q, deadband_q;
  logic [mapd_pkg::ENC_W-1:0]  home_offset_q, angle_scale_q;
  logic                        pid_mode_q;

  // Control and state
  mapd_pkg::st_e                state_q, state_d;
  mapd_pkg::ctl_t               ctl;
  logic [mapd_pkg::CNT_W-1:0]   cnt_q;
  logic [IW-1:0]                integ_q;
  logic [mapd_pkg::ERR_W-1:0]   prev_err_q;
  logic [mapd_pkg::TICK_W-1:0]  prev_tick_q;
  logic                         out_valid_q;

  // Item payload and working registers
  logic [mapd_pkg::ANGLE_W-1:0] angle_q;
  logic [mapd_pkg::ENC_W-1:0]   enc_q;
  logic [mapd_pkg::TICK_W-1:0]  tick_q;
  logic                         pair_q;
  logic [mapd_pkg::SETP_W-1:0]  setp_q;
  logic [mapd_pkg::ERR_W-1:0]   err_q;
  logic [mapd_pkg::ERR_W-1:0]   mag_q;
  logic                         neg_q;
  logic [mapd_pkg::TICK_W-1:0]  dt_q;
  logic [mapd_pkg::MUL_W-1:0]   mul_q;
  logic [mapd_pkg::KP_W-1:0]    kp_q;
  logic [mapd_pkg::TICK_W+mapd_pkg::DIVN_W-1:0] rq_q;
  logic [mapd_pkg::DUTY_W-1:0]  iterm_q;
  logic [mapd_pkg::DUTY_W-1:0]  fwd_q, rev_q, duty_q;
  logic                         pair_out_q;

  // Combinational datapath
  logic [mapd_pkg::ERR_W-1:0]   mcand;
  logic [mapd_pkg::KD_W+1:0]    mul_sum;
  logic [mapd_pkg::MUL_W-1:0]   mul_d;
  logic [IW:0]                  kp_sum;
  logic [mapd_pkg::KP_W-1:0]    kp_d;
  logic [mapd_pkg::TICK_W:0]    div_hi;
  logic [mapd_pkg::TICK_W+1:0]  div_trial;
  logic                         div_qbit;
  logic [mapd_pkg::TICK_W-1:0]  div_rem;
  logic [mapd_pkg::SETP_W-1:0]  setp_c, err_raw;
  logic [mapd_pkg::ERR_W-1:0]   err_c;
  logic [IW:0]                  integ_sum;
  logic [mapd_pkg::ERR_W:0]     diff_c;
  logic [mapd_pkg::ERR_W-1:0]   mag_c;
  logic [IW-1:0]                ival;
  logic [mapd_pkg::DUTY_W-1:0]  iterm_c;
  logic signed [mapd_pkg::SUM_W-1:0] dval, sum_s;
  logic                         dmax;
  logic [mapd_pkg::DUTY_W-1:0]  duty_c, fwd_c, rev_c;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ki_gain_q     <= 32'd4724;
      kd_gain_q     <= 16'd2560;
      max_duty_q    <= 16'd1000;
      min_duty_q    <= 16'd0;
      deadband_q    <= 16'd10;
      home_offset_q <= 16'd0;
      angle_scale_q <= 16'd1067;
      pid_mode_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mapd_pkg::REG_KI:    ki_gain_q     <= cfg_wdata_i;
        mapd_pkg::REG_KD:    kd_gain_q     <= cfg_wdata_i[mapd_pkg::KD_W-1:0];
        mapd_pkg::REG_MAX:   max_duty_q    <= cfg_wdata_i[mapd_pkg::DUTY_W-1:0];
        mapd_pkg::REG_MIN:   min_duty_q    <= cfg_wdata_i[mapd_pkg::DUTY_W-1:0];
        mapd_pkg::REG_DBAND: deadband_q    <= cfg_wdata_i[mapd_pkg::DUTY_W-1:0];
        mapd_pkg::REG_HOME:  home_offset_q <= cfg_wdata_i[mapd_pkg::ENC_W-1:0];
        mapd_pkg::REG_SCALE: angle_scale_q <= cfg_wdata_i[mapd_pkg::ENC_W-1:0];
        mapd_pkg::REG_MODE:  pid_mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mapd_pkg::ST_IDLE: if (in_valid_i) state_d = mapd_pkg::ST_SETP;
      mapd_pkg::ST_SETP: begin
        if (cnt_q == mapd_pkg::CNT_W'(mapd_pkg::SETP_STEPS - 1)) state_d = mapd_pkg::ST_ERR;
      end
      mapd_pkg::ST_ERR:  state_d = mapd_pkg::ST_INT;
      mapd_pkg::ST_INT:  state_d = mapd_pkg::ST_MUL;
      mapd_pkg::ST_MUL: begin
        if (cnt_q == mapd_pkg::CNT_W'(mapd_pkg::MUL_STEPS - 1)) state_d = mapd_pkg::ST_DIV;
      end
      mapd_pkg::ST_DIV: begin
        if (cnt_q == mapd_pkg::CNT_W'(mapd_pkg::DIV_STEPS - 1)) state_d = mapd_pkg::ST_SUM;
      end
      mapd_pkg::ST_SUM:  if (!out_valid_q || out_ready_i) state_d = mapd_pkg::ST_IDLE;
      default:           state_d = mapd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: controls
  always_comb begin
    ctl = '0;
    unique case (state_q)
      mapd_pkg::ST_IDLE: ctl.accept = in_valid_i;
      mapd_pkg::ST_SETP: ctl.mul_step = 1'b1;
      mapd_pkg::ST_MUL: begin
        ctl.ki_step  = 1'b1;
        ctl.mul_step = (cnt_q < mapd_pkg::CNT_W'(mapd_pkg::KD_W));
      end
      mapd_pkg::ST_DIV:  ctl.div_step = 1'b1;
      mapd_pkg::ST_SUM:  ctl.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == mapd_pkg::ST_IDLE);

  // Shared shift-add multiplier, one multiplier bit per cycle, LSB first.
  assign mcand   = (state_q == mapd_pkg::ST_SETP) ? angle_q : mag_q;
  assign mul_sum = {1'b0, mul_q[mapd_pkg::MUL_W-1:mapd_pkg::KD_W]}
                 + (mul_q[0] ? {1'b0, mcand} : '0);
  assign mul_d   = {mul_sum, mul_q[mapd_pkg::KD_W-1:1]};

  // Integral-gain multiplier, one gain bit per cycle.
  assign kp_sum = {1'b0, kp_q[mapd_pkg::KP_W-1:mapd_pkg::KI_W]}
                + (kp_q[0] ? {1'b0, integ_q} : '0);
  assign kp_d   = {kp_sum, kp_q[mapd_pkg::KI_W-1:1]};

  // Restoring divider: the remainder sits above the numerator, which shifts out MSB first.
  assign div_hi    = rq_q[mapd_pkg::TICK_W+mapd_pkg::DIVN_W-1:mapd_pkg::DIVN_W-1];
  assign div_trial = {1'b0, div_hi} - {2'b00, dt_q};
  assign div_qbit  = !div_trial[mapd_pkg::TICK_W+1];
  assign div_rem   = div_qbit ? div_trial[mapd_pkg::TICK_W-1:0]
                              : div_hi[mapd_pkg::TICK_W-1:0];

  // Setpoint and saturated absolute error.
  always_comb begin
    setp_c = mapd_pkg::SETP_W'(home_offset_q)
           + mapd_pkg::SETP_W'(mul_q[mapd_pkg::MUL_W-1:mapd_pkg::KD_W]);
    if (setp_c > mapd_pkg::SETP_W'(enc_q)) begin
      err_raw = setp_c - mapd_pkg::SETP_W'(enc_q);
    end else begin
      err_raw = mapd_pkg::SETP_W'(enc_q) - setp_c;
    end
    err_c = err_raw[mapd_pkg::SETP_W-1] ? mapd_pkg::ERR_MAX : err_raw[mapd_pkg::ERR_W-1:0];
  end

  // Integral update and the change in error.
  assign integ_sum = {1'b0, integ_q} + (IW+1)'(err_q);
  assign diff_c    = {1'b0, err_q} - {1'b0, prev_err_q};
  assign mag_c     = diff_c[mapd_pkg::ERR_W] ? mapd_pkg::ERR_W'(-diff_c)
                                             : diff_c[mapd_pkg::ERR_W-1:0];

  // Integral term with its clamp; the upper bound wins when the bounds cross.
  always_comb begin
    ival = pid_mode_q ? kp_q[mapd_pkg::KP_W-1:mapd_pkg::KI_W] : {1'b0, integ_q[IW-1:1]};
    priority if (ival > IW'(max_duty_q)) begin
      iterm_c = max_duty_q;
    end else if (ival < IW'(min_duty_q)) begin
      iterm_c = min_duty_q;
    end else begin
      iterm_c = ival[mapd_pkg::DUTY_W-1:0];
    end
  end

  // Final sum, clamp and H-bridge direction.
  always_comb begin
    dval = '0;
    if (pid_mode_q) begin
      dval = neg_q ? -$signed({2'b00, rq_q[mapd_pkg::DIVN_W-1:0]})
                   :  $signed({2'b00, rq_q[mapd_pkg::DIVN_W-1:0]});
    end
    dmax  = pid_mode_q && (dt_q == '0);
    sum_s = $signed(mapd_pkg::SUM_W'(err_q)) + $signed(mapd_pkg::SUM_W'(iterm_q)) + dval;
    priority if (dmax || (sum_s > $signed(mapd_pkg::SUM_W'(max_duty_q)))) begin
      duty_c = max_duty_q;
    end else if (sum_s < $signed(mapd_pkg::SUM_W'(min_duty_q))) begin
      duty_c = min_duty_q;
    end else begin
      duty_c = sum_s[mapd_pkg::DUTY_W-1:0];
    end
    fwd_c = '0;
    rev_c = '0;
    // Below the setpoint drives reverse; the deadband only lies on the upper side.
    priority if (mapd_pkg::SETP_W'(enc_q) < setp_q) begin
      rev_c = duty_c;
    end else if ((mapd_pkg::SETP_W'(enc_q) - setp_q) < mapd_pkg::SETP_W'(deadband_q)) begin
      rev_c = '0;
    end else begin
      fwd_c = duty_c;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mapd_pkg::ST_IDLE;
      cnt_q       <= '0;
      integ_q     <= '0;
      prev_err_q  <= '0;
      prev_tick_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
      if (state_q == mapd_pkg::ST_INT) begin
        integ_q     <= integ_sum[IW] ? {IW{1'b1}} : integ_sum[IW-1:0];
        prev_err_q  <= err_q;
        prev_tick_q <= tick_q;
      end
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      angle_q <= target_angle_i;
      enc_q   <= encoder_position_i;
      tick_q  <= current_tick_i;
      pair_q  <= channel_pair_i;
      mul_q   <= {{mapd_pkg::ERR_W{1'b0}}, angle_scale_q};
    end else if (ctl.mul_step) begin
      mul_q <= mul_d;
    end else if (state_q == mapd_pkg::ST_INT) begin
      mul_q <= {{mapd_pkg::ERR_W{1'b0}}, kd_gain_q};
    end
    if (state_q == mapd_pkg::ST_ERR) begin
      setp_q <= setp_c;
      err_q  <= err_c;
    end
    if (state_q == mapd_pkg::ST_INT) begin
      mag_q <= mag_c;
      neg_q <= diff_c[mapd_pkg::ERR_W];
      dt_q  <= tick_q - prev_tick_q;
      kp_q  <= {{IW{1'b0}}, ki_gain_q};
    end else if (ctl.ki_step) begin
      kp_q <= kp_d;
    end
    // The derivative product is complete long before the last multiply cycle.
    if (state_q == mapd_pkg::ST_MUL) begin
      rq_q <= {{mapd_pkg::TICK_W{1'b0}}, mul_q[mapd_pkg::MUL_W-1:8]};
    end else if (ctl.div_step) begin
      rq_q <= {div_rem, rq_q[mapd_pkg::DIVN_W-2:0], div_qbit};
    end
    if (ctl.div_step) begin
      iterm_q <= iterm_c;
    end
    if (ctl.out_load) begin
      fwd_q      <= fwd_c;
      rev_q      <= rev_c;
      duty_q     <= duty_c;
      pair_out_q <= pair_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_forward_o = fwd_q;
  assign duty_reverse_o = rev_q;
  assign pid_duty_o     = duty_q;
  assign pair_used_o    = pair_out_q;

  `MAPD_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == mapd_pkg::ST_SETP)
  `MAPD_ASSERT_SAME(a_result_from_sum, $rose(out_valid_q), $past(state_q) == mapd_pkg::ST_SUM)
  `MAPD_ASSERT_NEXT(a_integral_rises, state_q == mapd_pkg::ST_INT, integ_q >= $past(integ_q))
  `MAPD_ASSERT_NEXT(a_zero_dt_max, ctl.out_load && pid_mode_q && (dt_q == '0), duty_q == $past(max_duty_q))

endmodule

`default_nettype wire
